// ===== rtl/plem_pkg.sv =====
// ----------------------------------------------------------------------------
// plem_pkg
// Shared types and codes for the priority list with extract-max.
// ----------------------------------------------------------------------------
package plem_pkg;

   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int CNT_W    = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT  = 2'd0,
      MODE_EXTRACT = 2'd1,
      MODE_SEARCH  = 2'd2,
      MODE_COUNT   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   // per-cell load controls; take_load wins over take_next
   typedef struct packed {
      logic take_next;
      logic take_load;
   } cell_ctrl_type;

endpackage

// ===== rtl/plem_cell.sv =====
// ----------------------------------------------------------------------------
// plem_cell
// One list entry; takes its neighbor's entry or a new one on command.
// ----------------------------------------------------------------------------
module plem_cell #(
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16
) (
   input  logic                         clock,
   input  plem_pkg::cell_ctrl_type      ctrl,
   input  logic [PRIORITY_BITS-1:0]     next_priority,
   input  logic [TAG_BITS-1:0]          next_tag,
   input  logic [PRIORITY_BITS-1:0]     load_priority,
   input  logic [TAG_BITS-1:0]          load_tag,
   output logic [PRIORITY_BITS-1:0]     entry_priority,
   output logic [TAG_BITS-1:0]          entry_tag
);
   import plem_pkg::*;

   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [TAG_BITS-1:0]      tag_ff, tag_in;

   always_comb begin
      prio_in = prio_ff;
      tag_in  = tag_ff;
      if (ctrl.take_load) begin
         prio_in = load_priority;
         tag_in  = load_tag;
      end else if (ctrl.take_next) begin
         prio_in = next_priority;
         tag_in  = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
   end

   assign entry_priority = prio_ff;
   assign entry_tag      = tag_ff;

endmodule

// ===== rtl/plem_scan.sv =====
// ----------------------------------------------------------------------------
// plem_scan
// Watches entries leaving the head cell one per cycle and keeps the first
// maximum, the first match and the at-or-above count.
// ----------------------------------------------------------------------------
module plem_scan #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16,
   localparam int IDX_W        = $clog2(CAPACITY),
   localparam int NUM_W        = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     step,
   input  logic [IDX_W-1:0]         entry_idx,
   input  logic [PRIORITY_BITS-1:0] entry_priority,
   input  logic [TAG_BITS-1:0]      entry_tag,
   input  logic [PRIORITY_BITS-1:0] req_priority,
   output logic [PRIORITY_BITS-1:0] best_priority,
   output logic [TAG_BITS-1:0]      best_tag,
   output logic [IDX_W-1:0]         best_idx,
   output logic                     found,
   output logic [IDX_W-1:0]         found_pos,
   output logic [NUM_W-1:0]         ge_count
);
   import plem_pkg::*;

   logic                     have_best_ff, have_best_in;
   logic                     found_ff, found_in;
   logic [NUM_W-1:0]         ge_ff, ge_in;
   logic [PRIORITY_BITS-1:0] best_prio_ff, best_prio_in;
   logic [TAG_BITS-1:0]      best_tag_ff, best_tag_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;

   always_comb begin
      have_best_in = have_best_ff;
      found_in     = found_ff;
      ge_in        = ge_ff;
      best_prio_in = best_prio_ff;
      best_tag_in  = best_tag_ff;
      best_idx_in  = best_idx_ff;
      pos_in       = pos_ff;
      if (clear) begin
         have_best_in = 1'b0;
         found_in     = 1'b0;
         ge_in        = '0;
      end else if (step) begin
         // strict compare keeps the lowest index on ties
         if (!have_best_ff || entry_priority > best_prio_ff) begin
            have_best_in = 1'b1;
            best_prio_in = entry_priority;
            best_tag_in  = entry_tag;
            best_idx_in  = entry_idx;
         end
         if (!found_ff && entry_priority == req_priority) begin
            found_in = 1'b1;
            pos_in   = entry_idx;
         end
         if (entry_priority >= req_priority) begin
            ge_in = ge_ff + NUM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
         found_ff     <= 1'b0;
         ge_ff        <= '0;
      end else begin
         have_best_ff <= have_best_in;
         found_ff     <= found_in;
         ge_ff        <= ge_in;
      end
      best_prio_ff <= best_prio_in;
      best_tag_ff  <= best_tag_in;
      best_idx_ff  <= best_idx_in;
      pos_ff       <= pos_in;
   end

   assign best_priority = best_prio_ff;
   assign best_tag      = best_tag_ff;
   assign best_idx      = best_idx_ff;
   // search and count include the entry seen in the last scan cycle
   assign found         = found_in;
   assign found_pos     = pos_in;
   assign ge_count      = ge_in;

endmodule

// ===== rtl/priority_list_extract_max.sv =====
// ----------------------------------------------------------------------------
// priority_list_extract_max
// Arrival-ordered priority list held in a ring of cells, with extract-max.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; req_mode picks
// insert, extract highest priority, search priority or count at or above.
// Each request gives exactly one result, shown for one cycle with rsp_valid
// high; the receiver cannot stall, so results are never held back.
// Insert loads the cell at the tail directly in the ST_INSERT state, and the
// result strobe is registered from there. Extract, search and count rotate
// the whole ring of CAPACITY cells once past the head cell, where a scanner
// looks at one entry per cycle. Search, count and an extract on an empty
// list give their result after the ST_SCAN pass; any other extract gives it
// after an ST_SHIFT state that closes the gap by shifting the later cells
// down. busy drops in the cycle the result is shown, so a new request can be
// taken then, but none before the last one has its result. Reset empties
// the list and drops busy; cell contents are not cleared, only the entry
// count.
// ----------------------------------------------------------------------------
module priority_list_extract_max #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [plem_pkg::MODE_W-1:0]   req_mode,
   input  logic [PRIORITY_BITS-1:0]      req_priority_req,
   input  logic [TAG_BITS-1:0]           req_person_tag,
   output logic                          rsp_valid,
   output logic [plem_pkg::STATUS_W-1:0] rsp_status,
   output logic [TAG_BITS-1:0]           rsp_out_tag,
   output logic [PRIORITY_BITS-1:0]      rsp_out_priority,
   output logic [plem_pkg::POS_W-1:0]    rsp_position,
   output logic [plem_pkg::CNT_W-1:0]    rsp_count_ahead,
   output logic                          rsp_list_empty
);
   import plem_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int NUM_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   logic [NUM_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;

   mode_type                 mode_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;
   logic [TAG_BITS-1:0]      tag_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [PRIORITY_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0]         rsp_cnt_ff, rsp_cnt_in;
   logic                     rsp_empty_ff, rsp_empty_in;

   logic accept;
   logic scan_last;
   logic rotate_en, shift_en, load_en;

   logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
   logic [TAG_BITS-1:0]      cell_tag  [CAPACITY];

   logic [PRIORITY_BITS-1:0] best_priority;
   logic [TAG_BITS-1:0]      best_tag;
   logic [IDX_W-1:0]         best_idx;
   logic                     found;
   logic [IDX_W-1:0]         found_pos;
   logic [NUM_W-1:0]         ge_count;
   logic                     scan_step;

   logic [IDX_W+POS_W-1:0]   pos_ext;
   logic [NUM_W+CNT_W:0]     ge_ext;
   logic [NUM_W+CNT_W:0]     ge_less;

   assign accept    = start && (state_ff == ST_IDLE);
   assign scan_last = (scan_idx_ff == IDX_W'(CAPACITY - 1));
   assign scan_step = (state_ff == ST_SCAN) && (NUM_W'(scan_idx_ff) < count_ff);

   // ring of cells: cell i takes from cell i+1, the last one from cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_ctrl_type ctrl;
      assign ctrl.take_load = load_en && (count_ff == NUM_W'(i));
      assign ctrl.take_next = rotate_en || (shift_en && (IDX_W'(i) >= best_idx));

      plem_cell #(
         .PRIORITY_BITS(PRIORITY_BITS),
         .TAG_BITS     (TAG_BITS)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .next_priority (cell_prio[(i + 1) % CAPACITY]),
         .next_tag      (cell_tag[(i + 1) % CAPACITY]),
         .load_priority (prio_ff),
         .load_tag      (tag_ff),
         .entry_priority(cell_prio[i]),
         .entry_tag     (cell_tag[i])
      );
   end

   plem_scan #(
      .CAPACITY     (CAPACITY),
      .PRIORITY_BITS(PRIORITY_BITS),
      .TAG_BITS     (TAG_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .clear         (accept),
      .step          (scan_step),
      .entry_idx     (scan_idx_ff),
      .entry_priority(cell_prio[0]),
      .entry_tag     (cell_tag[0]),
      .req_priority  (prio_ff),
      .best_priority (best_priority),
      .best_tag      (best_tag),
      .best_idx      (best_idx),
      .found         (found),
      .found_pos     (found_pos),
      .ge_count      (ge_count)
   );

   assign pos_ext = {{POS_W{1'b0}}, found_pos};
   assign ge_ext  = {{(CNT_W + 1){1'b0}}, ge_count};
   assign ge_less = ge_ext - (NUM_W + CNT_W + 1)'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (mode_type'(req_mode) == MODE_INSERT) ? ST_INSERT : ST_SCAN;
            end
         end
         ST_INSERT: state_in = ST_IDLE;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = (mode_ff == MODE_EXTRACT && count_ff != '0) ? ST_SHIFT : ST_IDLE;
            end
         end
         ST_SHIFT: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      rotate_en     = 1'b0;
      shift_en      = 1'b0;
      load_en       = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_tag_in    = '0;
      rsp_prio_in   = '0;
      rsp_pos_in    = '0;
      rsp_cnt_in    = '0;
      case (state_ff)
         ST_IDLE: begin
            scan_idx_in = '0;
         end
         ST_INSERT: begin
            rsp_valid_in = 1'b1;
            if (count_ff == NUM_W'(CAPACITY)) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               load_en  = 1'b1;
               count_in = count_ff + NUM_W'(1);
            end
         end
         ST_SCAN: begin
            rotate_en   = 1'b1;
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (scan_last) begin
               case (mode_ff)
                  MODE_EXTRACT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  MODE_SEARCH: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        rsp_pos_in = pos_ext[POS_W-1:0];
                     end else begin
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  MODE_COUNT: begin
                     rsp_valid_in = 1'b1;
                     // one less than the number at or above, saturating
                     if (ge_count == '0) begin
                        rsp_cnt_in = '0;
                     end else if (ge_less > (NUM_W + CNT_W + 1)'(2 ** CNT_W - 1)) begin
                        rsp_cnt_in = '1;
                     end else begin
                        rsp_cnt_in = ge_less[CNT_W-1:0];
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_SHIFT: begin
            shift_en     = 1'b1;
            count_in     = count_ff - NUM_W'(1);
            rsp_valid_in = 1'b1;
            rsp_tag_in   = best_tag;
            rsp_prio_in  = best_priority;
         end
         default: ;
      endcase
      rsp_empty_in = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= mode_type'(req_mode);
         prio_ff <= req_priority_req;
         tag_ff  <= req_person_tag;
      end
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_cnt_ff    <= rsp_cnt_in;
         rsp_empty_ff  <= rsp_empty_in;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_count_ahead  = rsp_cnt_ff;
   assign rsp_list_empty   = rsp_empty_ff;

endmodule

// ===== rtl/plem_checker.sv =====
// ----------------------------------------------------------------------------
// plem_checker
// Port-level checks on the request/result timing and result fields of the priority list.
// ----------------------------------------------------------------------------
module plem_checker #(
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [plem_pkg::STATUS_W-1:0] rsp_status,
   input logic [TAG_BITS-1:0]           rsp_out_tag,
   input logic [PRIORITY_BITS-1:0]      rsp_out_priority,
   input logic                          rsp_list_empty
);
   import plem_pkg::*;

   // busy is high right after a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low right after a request was taken");

   // results come only as the block frees up
   a_result_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // result strobes never come two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> !rsp_list_empty)
      else $error("list reported full and empty together");

   a_fail_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_out_tag == '0 && rsp_out_priority == '0)
      else $error("entry returned with a failing status");

endmodule

bind priority_list_extract_max plem_checker #(
   .PRIORITY_BITS(PRIORITY_BITS),
   .TAG_BITS     (TAG_BITS)
) u_plem_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_out_tag     (rsp_out_tag),
   .rsp_out_priority(rsp_out_priority),
   .rsp_list_empty  (rsp_list_empty)
);

// ===== test/priority_list_checker.sv =====
// ----------------------------------------------------------------------------
// priority_list_checker
// Watches the request and result channels of the priority list, keeps its
// own copy of the list, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module priority_list_checker #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [plem_pkg::MODE_W-1:0]     req_mode,
   input  logic [PRIORITY_BITS-1:0]        req_priority_req,
   input  logic [TAG_BITS-1:0]             req_person_tag,
   input  logic                            rsp_valid,
   input  logic [plem_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [TAG_BITS-1:0]             rsp_out_tag,
   input  logic [PRIORITY_BITS-1:0]        rsp_out_priority,
   input  logic [plem_pkg::POS_W-1:0]      rsp_position,
   input  logic [plem_pkg::CNT_W-1:0]      rsp_count_ahead,
   input  logic                            rsp_list_empty,
   output int                              fail_count,
   output int                              results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import plem_pkg::*;

   typedef struct {
      status_type               status;
      logic [TAG_BITS-1:0]      tag;
      logic [PRIORITY_BITS-1:0] prio;
      logic [POS_W-1:0]         position;
      logic [CNT_W-1:0]         count_ahead;
      logic                     list_empty;
   } list_result_type;

   logic [PRIORITY_BITS-1:0] held_prio [CAPACITY];
   logic [TAG_BITS-1:0]      held_tag  [CAPACITY];
   int                       held_count;
   list_result_type          awaited_results[$];
   int                       mismatch_count;

   // applies one request to the local copy of the list and gives its result
   task automatic predict_list_op(input mode_type op,
                                  input logic [PRIORITY_BITS-1:0] prio,
                                  input logic [TAG_BITS-1:0] tag,
                                  output list_result_type r);
      int best;
      int hits;
      bit found;
      r.status      = STATUS_OK;
      r.tag         = '0;
      r.prio        = '0;
      r.position    = '0;
      r.count_ahead = '0;
      case (op)
         MODE_INSERT: begin
            if (held_count >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               held_prio[held_count] = prio;
               held_tag[held_count]  = tag;
               held_count++;
            end
         end
         MODE_EXTRACT: begin
            if (held_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               // strict compare keeps the lowest index on ties
               best = 0;
               for (int i = 1; i < held_count; i++)
                  if (held_prio[i] > held_prio[best]) best = i;
               r.prio = held_prio[best];
               r.tag  = held_tag[best];
               for (int i = best; i + 1 < held_count; i++) begin
                  held_prio[i] = held_prio[i+1];
                  held_tag[i]  = held_tag[i+1];
               end
               held_count--;
            end
         end
         MODE_SEARCH: begin
            r.status = STATUS_EMPTY;
            found    = 1'b0;
            for (int i = 0; i < held_count; i++) begin
               if (!found && held_prio[i] == prio) begin
                  found      = 1'b1;
                  r.status   = STATUS_OK;
                  r.position = POS_W'(i);
               end
            end
         end
         default: begin
            hits = 0;
            for (int i = 0; i < held_count; i++)
               if (held_prio[i] >= prio) hits++;
            if (hits == 0) r.count_ahead = '0;
            else if (hits - 1 > 15) r.count_ahead = CNT_W'(15);
            else r.count_ahead = CNT_W'(hits - 1);
         end
      endcase
      r.list_empty = (held_count == 0);
   endtask

   always @(posedge clock) begin
      list_result_type want;
      list_result_type next_result;
      if (reset) begin
         held_count = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               fail_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with no request outstanding: status %0d tag %h",
                           $realtime, rsp_status, rsp_out_tag);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status || rsp_out_tag !== want.tag ||
                   rsp_out_priority !== want.prio || rsp_position !== want.position ||
                   rsp_count_ahead !== want.count_ahead ||
                   rsp_list_empty !== want.list_empty) begin
                  mismatch_count++;
                  fail_count++;
                  if (mismatch_count <= 10) begin
                     $write("%0t: mismatch: expected status %0d tag %h prio %h pos %0d",
                            $realtime, want.status, want.tag, want.prio, want.position);
                     $write(" cnt %0d empty %0b, got status %0d tag %h prio %h pos %0d",
                            want.count_ahead, want.list_empty, rsp_status, rsp_out_tag,
                            rsp_out_priority, rsp_position);
                     $display(" cnt %0d empty %0b", rsp_count_ahead, rsp_list_empty);
                  end
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            predict_list_op(mode_type'(req_mode), req_priority_req, req_person_tag,
                            next_result);
            awaited_results.push_back(next_result);
         end
      end
      results_outstanding = awaited_results.size();
   end

endmodule

// ===== test/tb_priority_list_extract_max.sv =====
// ----------------------------------------------------------------------------
// tb_priority_list_extract_max
// Drives insert, extract, search and count requests into the priority list:
// a directed pass over empty, full, tie and miss cases, then random bursts
// that fill and drain the list, under varying request gaps.
// ----------------------------------------------------------------------------
module tb_priority_list_extract_max;
   timeunit 1ns;
   timeprecision 1ps;
   import plem_pkg::*;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int TAG_BITS      = 16;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [MODE_W-1:0]        req_mode;
   logic [PRIORITY_BITS-1:0] req_priority_req;
   logic [TAG_BITS-1:0]      req_person_tag;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   logic [TAG_BITS-1:0]      rsp_out_tag;
   logic [PRIORITY_BITS-1:0] rsp_out_priority;
   logic [POS_W-1:0]         rsp_position;
   logic [CNT_W-1:0]         rsp_count_ahead;
   logic                     rsp_list_empty;
   int                       fail_count;
   int                       results_outstanding;
   int                       sender_idle_pct;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   priority_list_extract_max #(
      .CAPACITY(CAPACITY), .PRIORITY_BITS(PRIORITY_BITS), .TAG_BITS(TAG_BITS)
   ) dut (
      .clock, .reset, .start, .busy, .req_mode, .req_priority_req, .req_person_tag,
      .rsp_valid, .rsp_status, .rsp_out_tag, .rsp_out_priority, .rsp_position,
      .rsp_count_ahead, .rsp_list_empty
   );

   priority_list_checker #(
      .CAPACITY(CAPACITY), .PRIORITY_BITS(PRIORITY_BITS), .TAG_BITS(TAG_BITS)
   ) checker_i (
      .clock, .reset, .start, .busy, .req_mode, .req_priority_req, .req_person_tag,
      .rsp_valid, .rsp_status, .rsp_out_tag, .rsp_out_priority, .rsp_position,
      .rsp_count_ahead, .rsp_list_empty, .fail_count, .results_outstanding
   );

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic issue_request(input mode_type op,
                                input logic [PRIORITY_BITS-1:0] prio,
                                input logic [TAG_BITS-1:0] tag);
      // each cycle the sender may sit idle
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start            = 1'b1;
      req_mode         = op;
      req_priority_req = prio;
      req_person_tag   = tag;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // mostly a few small values so that searches hit and extracts tie
   function automatic logic [PRIORITY_BITS-1:0] pick_priority();
      int r;
      r = $urandom_range(99);
      if (r < 50) return PRIORITY_BITS'($urandom_range(0, 7));
      if (r < 65) return '0;
      if (r < 80) return '1;
      return PRIORITY_BITS'($urandom);
   endfunction

   task automatic run_random_requests(input int n_items);
      bit filling;
      int burst_left;
      int r;
      mode_type op;
      filling    = 1'b1;
      burst_left = $urandom_range(20, 60);
      for (int n = 0; n < n_items; n++) begin
         if (burst_left == 0) begin
            filling    = !filling;
            burst_left = $urandom_range(20, 60);
         end
         burst_left--;
         r = $urandom_range(99);
         if (filling)
            op = r < 55 ? MODE_INSERT : r < 70 ? MODE_EXTRACT : r < 85 ? MODE_SEARCH
                                                                       : MODE_COUNT;
         else
            op = r < 20 ? MODE_INSERT : r < 65 ? MODE_EXTRACT : r < 85 ? MODE_SEARCH
                                                                       : MODE_COUNT;
         issue_request(op, pick_priority(), TAG_BITS'($urandom));
      end
   endtask

   initial begin
      logic [PRIORITY_BITS-1:0] fill_prio [CAPACITY] = '{
         8'd255, 8'd0, 8'd7, 8'd255, 8'd128, 8'd1, 8'd64, 8'd0,
         8'd254, 8'd3, 8'd127, 8'd200, 8'd5, 8'd9, 8'd99, 8'd42};
      logic [TAG_BITS-1:0] tag;
      reset            = 1'b1;
      start            = 1'b0;
      req_mode         = MODE_INSERT;
      req_priority_req = '0;
      req_person_tag   = '0;
      sender_idle_pct  = 36;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // empty list cases
      issue_request(MODE_EXTRACT, '0, '0);
      issue_request(MODE_SEARCH, '0, '0);
      issue_request(MODE_COUNT, '0, '0);
      // fill to capacity, then one insert too many
      for (int i = 0; i < CAPACITY; i++) begin
         tag = i == 0 ? '1 : i == 1 ? '0 : TAG_BITS'($urandom);
         issue_request(MODE_INSERT, fill_prio[i], tag);
      end
      issue_request(MODE_INSERT, 8'd77, 16'h5A5A);
      issue_request(MODE_SEARCH, 8'd255, '0);
      issue_request(MODE_SEARCH, 8'd0, '0);
      issue_request(MODE_SEARCH, 8'd2, '0);
      issue_request(MODE_COUNT, 8'd0, '0);
      issue_request(MODE_COUNT, 8'd255, '0);
      // two entries tie at the top priority
      issue_request(MODE_EXTRACT, '0, '0);
      issue_request(MODE_EXTRACT, '0, '0);

      run_random_requests(380);
      sender_idle_pct = 67;
      run_random_requests(380);
      sender_idle_pct = 0;
      run_random_requests(390);
      start = 1'b0;

      while (results_outstanding != 0) @(posedge clock);
      repeat (CAPACITY + 4) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #10ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
